/* hdl/gamepad_uart_frame_decoder_assert.svh */
// Assertion macros for the gamepad frame decoder modules, used by gpfd_back.
// They expand to nothing when SYNTHESIS is defined.
`ifndef GAMEPAD_UART_FRAME_DECODER_ASSERT_SVH
`define GAMEPAD_UART_FRAME_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define GPFD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gpfd assertion failed");
`define GPFD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("gpfd assertion failed");
`else
`define GPFD_ASSERT(label, clk, rst_n, prop)
`define GPFD_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* hdl/gpfd_pkg.sv */
// Package of the gamepad frame decoder: constants, command type, button decode.
// No dependencies.
`timescale 1ns / 1ps
package gpfd_pkg;

    localparam logic [7:0] START_BYTE   = 8'h80;
    localparam logic [7:0] AXIS_NEUTRAL = 8'd64;
    localparam logic [3:0] CHECK_POS    = 4'd7;
    localparam logic [3:0] IDLE_POS     = 4'd8;
    localparam int         NUM_AXES     = 4;
    localparam int         BTN_W        = 14;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_COMMIT,
        OP_TICK
    } gpfd_op_t;

    typedef struct packed {
        gpfd_op_t                      op;
        logic [BTN_W-1:0]              buttons;
        logic [NUM_AXES-1:0][7:0]      axes;
    } gpfd_cmd_t;

    // Up with down reads as start, right with left reads as select.
    function automatic logic [BTN_W-1:0] decode_buttons(input logic [7:0] b1,
                                                        input logic [7:0] b2);
        logic [BTN_W-1:0] btn;
        btn = '0;
        if (b2[0] && b2[1])
            btn[4] = 1'b1;
        else if (b2[0])
            btn[0] = 1'b1;
        else if (b2[1])
            btn[1] = 1'b1;
        if (b2[2] && b2[3])
            btn[5] = 1'b1;
        else if (b2[2])
            btn[2] = 1'b1;
        else if (b2[3])
            btn[3] = 1'b1;
        btn[8:6]  = b2[6:4];
        btn[13:9] = b1[4:0];
        return btn;
    endfunction

endpackage

/* hdl/gpfd_if.sv */
// Valid/ready channel interfaces of the gamepad frame decoder.
// No dependencies.
`timescale 1ns / 1ps
interface gpfd_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] byte_value;

    modport source (output valid, output req_type, output byte_value, input ready);
    modport sink   (input valid, input req_type, input byte_value, output ready);
endinterface

interface gpfd_out_if;
    logic        valid;
    logic        ready;
    logic [13:0] buttons;
    logic [7:0]  left_horizontal;
    logic [7:0]  left_vertical;
    logic [7:0]  right_horizontal;
    logic [7:0]  right_vertical;
    logic        frame_accepted;
    logic        timed_out;

    modport source (output valid, output buttons, output left_horizontal,
                    output left_vertical, output right_horizontal,
                    output right_vertical, output frame_accepted,
                    output timed_out, input ready);
    modport sink   (input valid, input buttons, input left_horizontal,
                    input left_vertical, input right_horizontal,
                    input right_vertical, input frame_accepted,
                    input timed_out, output ready);
endinterface

/* hdl/gpfd_front.sv */
// Front end: tracks the frame position and running checksum, and turns each
// transaction into a command. Depends on gpfd_pkg and gpfd_if.
`timescale 1ns / 1ps
module gpfd_front (
    input  logic               clk,
    input  logic               rst_n,
    gpfd_in_if.sink            in_ch,
    input  logic               push_ready,
    output logic               push_valid,
    output gpfd_pkg::gpfd_cmd_t push_cmd
);
    import gpfd_pkg::*;

    logic [3:0] pos_reg, pos_next;
    logic [6:0] sum_reg, sum_next;
    logic [7:0] store_reg [8];
    logic [3:0] pos;
    logic       accept;

    assign accept       = in_ch.valid && push_ready;
    assign in_ch.ready  = push_ready;
    assign push_valid   = in_ch.valid;

    always_comb
    begin
        pos      = (in_ch.byte_value == START_BYTE) ? 4'd0 : pos_reg;
        pos_next = pos_reg;
        sum_next = sum_reg;
        push_cmd.op      = OP_NONE;
        push_cmd.buttons = decode_buttons(store_reg[1], store_reg[2]);
        push_cmd.axes[0] = store_reg[3];
        push_cmd.axes[1] = store_reg[4];
        push_cmd.axes[2] = store_reg[5];
        push_cmd.axes[3] = store_reg[6];
        if (in_ch.req_type == REQ_TICK)
        begin
            push_cmd.op = OP_TICK;
        end
        else
        begin
            pos_next = pos;
            if (pos < IDLE_POS)
            begin
                pos_next = pos + 4'd1;
                if (pos == 4'd0)
                    sum_next = '0;
                else if (pos < CHECK_POS)
                    sum_next = sum_reg + in_ch.byte_value[6:0];
                else if (in_ch.byte_value == {1'b0, sum_reg})
                    push_cmd.op = OP_COMMIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            sum_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    // Frame bytes need no reset: each one is written before it is decoded.
    always_ff @(posedge clk)
    begin
        if (accept && in_ch.req_type == REQ_BYTE && pos < IDLE_POS)
        begin
            store_reg[pos[2:0]] <= in_ch.byte_value;
        end
    end

endmodule

/* hdl/gpfd_queue.sv */
// Two-entry command queue between the front end and the state update.
// Depends on gpfd_pkg.
`timescale 1ns / 1ps
module gpfd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  gpfd_pkg::gpfd_cmd_t push_cmd,
    output logic                pop_valid,
    input  logic                pop_ready,
    output gpfd_pkg::gpfd_cmd_t pop_cmd
);
    import gpfd_pkg::*;

    gpfd_cmd_t  entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

/* hdl/gpfd_back.sv */
// Back end: holds the decoded gamepad state and the output register.
// Depends on gpfd_pkg, gpfd_if and the assertion header.
`timescale 1ns / 1ps
`include "gamepad_uart_frame_decoder_assert.svh"
module gpfd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  gpfd_pkg::gpfd_cmd_t pop_cmd,
    gpfd_out_if.source          out_ch
);
    import gpfd_pkg::*;

    logic [BTN_W-1:0]         buttons_reg, buttons_next;
    logic [NUM_AXES-1:0][7:0] axes_reg, axes_next;
    logic                     no_frame_reg, no_frame_next;
    logic                     out_valid_reg;
    logic [BTN_W-1:0]         obuttons_reg;
    logic [NUM_AXES-1:0][7:0] oaxes_reg;
    logic                     oaccepted_reg, otimed_out_reg;
    logic                     pop, timed_out;

    assign pop_ready = !out_valid_reg || out_ch.ready;
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        buttons_next  = buttons_reg;
        axes_next     = axes_reg;
        no_frame_next = no_frame_reg;
        timed_out     = 1'b0;
        case (pop_cmd.op)
            OP_COMMIT:
            begin
                buttons_next  = pop_cmd.buttons;
                axes_next     = pop_cmd.axes;
                no_frame_next = 1'b0;
            end
            OP_TICK:
            begin
                if (no_frame_reg)
                begin
                    buttons_next = '0;
                    axes_next    = {NUM_AXES{AXIS_NEUTRAL}};
                    timed_out    = 1'b1;
                end
                no_frame_next = 1'b1;
            end
            default:
            begin
                buttons_next = buttons_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buttons_reg   <= '0;
            axes_reg      <= {NUM_AXES{AXIS_NEUTRAL}};
            no_frame_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                buttons_reg  <= buttons_next;
                axes_reg     <= axes_next;
                no_frame_reg <= no_frame_next;
            end
            if (pop)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            obuttons_reg   <= buttons_next;
            oaxes_reg      <= axes_next;
            oaccepted_reg  <= (pop_cmd.op == OP_COMMIT);
            otimed_out_reg <= timed_out;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.buttons          = obuttons_reg;
    assign out_ch.left_horizontal  = oaxes_reg[0];
    assign out_ch.left_vertical    = oaxes_reg[1];
    assign out_ch.right_horizontal = oaxes_reg[2];
    assign out_ch.right_vertical   = oaxes_reg[3];
    assign out_ch.frame_accepted   = oaccepted_reg;
    assign out_ch.timed_out        = otimed_out_reg;

    // A good frame clears the no-frame flag; every tick sets it again.
    `GPFD_ASSERT(a_commit_clears_flag, clk, rst_n,
        (pop && pop_cmd.op == OP_COMMIT) |=> !no_frame_reg)
    `GPFD_ASSERT(a_tick_sets_flag, clk, rst_n,
        (pop && pop_cmd.op == OP_TICK) |=> no_frame_reg)
    // A tick that times out leaves the state neutral in both copies.
    `GPFD_ASSERT(a_timeout_neutral, clk, rst_n,
        (pop && pop_cmd.op == OP_TICK && no_frame_reg)
            |=> (buttons_reg == '0 && axes_reg == {NUM_AXES{AXIS_NEUTRAL}}
                 && out_ch.timed_out && !out_ch.frame_accepted))
    // The output register always mirrors the state after the last transaction.
    `GPFD_ASSERT(a_out_mirrors_state, clk, rst_n,
        pop |=> (obuttons_reg == buttons_reg && oaxes_reg == axes_reg))

endmodule

/* hdl/gamepad_uart_frame_decoder.sv */
// Serial gamepad frame decoder, top level: front end, command queue, back end.
// Depends on gpfd_pkg, gpfd_if, gpfd_front, gpfd_queue and gpfd_back.
`timescale 1ns / 1ps
// Takes received UART bytes and timeout ticks on in_ch and returns one result
// per input transaction on out_ch: the decoded buttons and stick axes after
// that transaction, plus frame_accepted for a byte that completed a frame with
// a good checksum and timed_out for a tick that found no good frame since the
// previous tick. The block accepts one transaction every cycle while the
// queue has room; the front end keeps the frame position and a running
// checksum, so each byte is handled as it arrives. A result passes through
// the two-entry queue and then the output register on its way to out_ch, and
// the queue lets input continue while out_ch is stalled, until it is full.
module gamepad_uart_frame_decoder (
    input  logic       clk,
    input  logic       rst_n,
    gpfd_in_if.sink    in_ch,
    gpfd_out_if.source out_ch
);
    import gpfd_pkg::*;

    logic      push_valid, push_ready;
    gpfd_cmd_t push_cmd;
    logic      pop_valid, pop_ready;
    gpfd_cmd_t pop_cmd;

    gpfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    gpfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    gpfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .out_ch    (out_ch)
    );

endmodule
